[hdl/lse_pkg.sv]
`timescale 1ns / 1ps

package lse_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int BIT_IDX_W  = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int MAGIC_W    = 8;
    localparam int EXT_W      = 4;
    localparam int STATUS_W   = 2;

    // item queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_MAGIC_LEN,
        PH_MAGIC,
        PH_EXT_LEN,
        PH_EXT,
        PH_SIZE,
        PH_SECRET,
        PH_DONE
    } phase_t;

    typedef enum logic {
        CMD_COVER   = 1'b0,
        CMD_PAYLOAD = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_UNDERRUN = 2'd1,
        ST_OVERRUN  = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAGIC_LENGTH     = 2'd0,
        CFG_EXTENSION_LENGTH = 2'd1,
        CFG_SECRET_SIZE      = 2'd2
    } cfg_index_t;

    typedef struct packed {
        cmd_t              command;
        logic [BYTE_W-1:0] item_byte;
    } item_t;

    function automatic logic is_byte_section(input phase_t ph);
        return (ph == PH_MAGIC) || (ph == PH_EXT) || (ph == PH_SECRET);
    endfunction

    function automatic logic [WORD_W-1:0] section_len(
        input phase_t             ph,
        input logic [MAGIC_W-1:0] magic_length,
        input logic [EXT_W-1:0]   extension_length,
        input logic [WORD_W-1:0]  secret_size
    );
        logic [WORD_W-1:0] len;
        case (ph)
            PH_MAGIC: len = {{(WORD_W-MAGIC_W){1'b0}}, magic_length};
            PH_EXT:   len = {{(WORD_W-EXT_W){1'b0}}, extension_length};
            default:  len = secret_size;
        endcase
        return len;
    endfunction

    function automatic phase_t next_phase(input phase_t ph);
        return phase_t'(3'(ph) + 3'd1);
    endfunction

endpackage

[hdl/lse_in_if.sv]
`timescale 1ns / 1ps

interface lse_in_if;
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [lse_pkg::BYTE_W-1:0] item_byte;

    modport source (output valid, output command, output item_byte, input ready);
    modport sink   (input valid, input command, input item_byte, output ready);
endinterface

[hdl/lse_out_if.sv]
`timescale 1ns / 1ps

interface lse_out_if;
    logic                         valid;
    logic                         ready;
    logic [lse_pkg::BYTE_W-1:0]   stego_byte;
    logic [lse_pkg::STATUS_W-1:0] status;
    logic                         bit_embedded;

    modport source (output valid, output stego_byte, output status, output bit_embedded,
                    input ready);
    modport sink   (input valid, input stego_byte, input status, input bit_embedded,
                    output ready);
endinterface

[hdl/lse_front.sv]
`timescale 1ns / 1ps

module lse_front
(
    input  logic           clk,
    input  logic           rst_n,
    lse_in_if.sink         in_ch,
    output logic           q_valid,
    output lse_pkg::item_t q_item,
    input  logic           q_pop
);

    lse_pkg::item_t                    entry_reg [lse_pkg::QUEUE_DEPTH];
    logic [lse_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [lse_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [lse_pkg::QCNT_W-1:0]        count_reg;
    logic [lse_pkg::QCNT_W-1:0]        count_next;
    lse_pkg::item_t                    in_item;
    logic                              push;
    logic                              pop;

    // classify the raw transfer into a typed item
    always_comb
    begin
        in_item.command   = in_ch.command ? lse_pkg::CMD_PAYLOAD : lse_pkg::CMD_COVER;
        in_item.item_byte = in_ch.item_byte;
    end

    assign in_ch.ready = (count_reg != lse_pkg::QCNT_W'(lse_pkg::QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (count_reg != '0);
    assign pop         = q_pop && q_valid;
    assign q_item      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + lse_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - lse_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + lse_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + lse_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[hdl/lse_back.sv]
`timescale 1ns / 1ps

module lse_back
#(
    parameter int HEADER_BYTES = 54
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [lse_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lse_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               q_valid,
    input  lse_pkg::item_t                     q_item,
    output logic                               q_pop,
    lse_out_if.source                          out_ch
);

    localparam int HC_W = (HEADER_BYTES > 0) ? $clog2(HEADER_BYTES + 1) : 1;
    localparam logic [HC_W-1:0] HB_VAL = HC_W'(HEADER_BYTES);

    logic [lse_pkg::MAGIC_W-1:0]   magic_length_reg;
    logic [lse_pkg::EXT_W-1:0]     extension_length_reg;
    logic [lse_pkg::WORD_W-1:0]    secret_size_reg;

    lse_pkg::phase_t               phase_reg, phase_next;
    logic [HC_W-1:0]               header_count_reg, header_count_next;
    logic [lse_pkg::BIT_IDX_W-1:0] bit_index_reg, bit_index_next;
    logic [lse_pkg::WORD_W-1:0]    byte_count_reg, byte_count_next;
    logic [lse_pkg::BYTE_W-1:0]    payload_hold_reg, payload_hold_next;
    logic                          hold_valid_reg, hold_valid_next;

    logic                          out_valid_reg;
    logic [lse_pkg::BYTE_W-1:0]    stego_byte_reg;
    lse_pkg::status_t              status_reg;
    logic                          bit_embedded_reg;

    logic                          res_valid;
    logic [lse_pkg::BYTE_W-1:0]    res_byte;
    lse_pkg::status_t              res_status;
    logic                          res_embedded;

    assign q_pop = q_valid && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        lse_pkg::phase_t            ph;
        logic [lse_pkg::WORD_W-1:0] fld;
        logic                       bit_val;
        logic                       underrun;

        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        bit_index_next    = bit_index_reg;
        byte_count_next   = byte_count_reg;
        payload_hold_next = payload_hold_reg;
        hold_valid_next   = hold_valid_reg;
        res_valid         = 1'b0;
        res_byte          = q_item.item_byte;
        res_status        = lse_pkg::ST_OK;
        res_embedded      = 1'b0;
        ph                = phase_reg;
        fld               = '0;
        bit_val           = 1'b0;
        underrun          = 1'b0;

        if (q_pop)
        begin
            if (q_item.command == lse_pkg::CMD_PAYLOAD)
            begin
                if (hold_valid_reg)
                begin
                    res_valid  = 1'b1;
                    res_byte   = '0;
                    res_status = lse_pkg::ST_OVERRUN;
                end
                else
                begin
                    payload_hold_next = q_item.item_byte;
                    hold_valid_next   = 1'b1;
                end
            end
            else
            begin
                res_valid = 1'b1;

                // skip past finished or empty sections, lengths read live
                if (ph == lse_pkg::PH_HEADER && header_count_reg >= HB_VAL)
                begin
                    ph             = lse_pkg::PH_MAGIC_LEN;
                    bit_index_next = '0;
                end
                else if (lse_pkg::is_byte_section(ph) &&
                         byte_count_reg >= lse_pkg::section_len(ph, magic_length_reg,
                                               extension_length_reg, secret_size_reg))
                begin
                    ph              = lse_pkg::next_phase(ph);
                    byte_count_next = '0;
                    bit_index_next  = '0;
                end

                case (ph)
                    lse_pkg::PH_HEADER:
                    begin
                        header_count_next = header_count_reg + HC_W'(1);
                        if (header_count_next >= HB_VAL)
                        begin
                            ph             = lse_pkg::PH_MAGIC_LEN;
                            bit_index_next = '0;
                        end
                    end
                    lse_pkg::PH_MAGIC_LEN, lse_pkg::PH_EXT_LEN, lse_pkg::PH_SIZE:
                    begin
                        case (ph)
                            lse_pkg::PH_MAGIC_LEN:
                                fld = {{(lse_pkg::WORD_W-lse_pkg::MAGIC_W){1'b0}},
                                       magic_length_reg};
                            lse_pkg::PH_EXT_LEN:
                                fld = {{(lse_pkg::WORD_W-lse_pkg::EXT_W){1'b0}},
                                       extension_length_reg};
                            default:
                                fld = secret_size_reg;
                        endcase
                        // msb first: bit 31 minus index
                        bit_val      = fld[~bit_index_next];
                        res_embedded = 1'b1;
                        if (bit_index_next == '1)
                        begin
                            bit_index_next  = '0;
                            byte_count_next = '0;
                            ph              = lse_pkg::next_phase(ph);
                        end
                        else
                        begin
                            bit_index_next = bit_index_next + lse_pkg::BIT_IDX_W'(1);
                        end
                    end
                    lse_pkg::PH_MAGIC, lse_pkg::PH_EXT, lse_pkg::PH_SECRET:
                    begin
                        if (!hold_valid_reg)
                        begin
                            underrun   = 1'b1;
                            res_status = lse_pkg::ST_UNDERRUN;
                        end
                        else
                        begin
                            bit_val      = payload_hold_reg[~bit_index_next[2:0]];
                            res_embedded = 1'b1;
                            if (bit_index_next[2:0] == 3'd7)
                            begin
                                bit_index_next  = '0;
                                hold_valid_next = 1'b0;
                                byte_count_next = byte_count_next + lse_pkg::WORD_W'(1);
                            end
                            else
                            begin
                                bit_index_next = bit_index_next + lse_pkg::BIT_IDX_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (!underrun && lse_pkg::is_byte_section(ph) &&
                    byte_count_next >= lse_pkg::section_len(ph, magic_length_reg,
                                           extension_length_reg, secret_size_reg))
                begin
                    ph              = lse_pkg::next_phase(ph);
                    byte_count_next = '0;
                    bit_index_next  = '0;
                end

                if (res_embedded)
                begin
                    res_byte = {q_item.item_byte[lse_pkg::BYTE_W-1:1], bit_val};
                end
                phase_next = ph;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= lse_pkg::PH_HEADER;
            header_count_reg     <= '0;
            bit_index_reg        <= '0;
            byte_count_reg       <= '0;
            payload_hold_reg     <= '0;
            hold_valid_reg       <= 1'b0;
            magic_length_reg     <= '0;
            extension_length_reg <= '0;
            secret_size_reg      <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            bit_index_reg    <= bit_index_next;
            byte_count_reg   <= byte_count_next;
            payload_hold_reg <= payload_hold_next;
            hold_valid_reg   <= hold_valid_next;

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    lse_pkg::CFG_MAGIC_LENGTH:
                        magic_length_reg <= cfg_data[lse_pkg::MAGIC_W-1:0];
                    lse_pkg::CFG_EXTENSION_LENGTH:
                        extension_length_reg <= cfg_data[lse_pkg::EXT_W-1:0];
                    lse_pkg::CFG_SECRET_SIZE:
                        secret_size_reg <= cfg_data[lse_pkg::WORD_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (q_pop && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && res_valid)
        begin
            stego_byte_reg   <= res_byte;
            status_reg       <= res_status;
            bit_embedded_reg <= res_embedded;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.stego_byte   = stego_byte_reg;
    assign out_ch.status       = status_reg;
    assign out_ch.bit_embedded = bit_embedded_reg;

endmodule

[hdl/lsb_stego_embedder.sv]
`timescale 1ns / 1ps

// LSB embedder for a BMP byte stream. Cover bytes and payload bytes share one
// input channel; every cover byte gives one result, a payload byte gives a
// result only when it is dropped as an overrun. The block takes one item per
// clock while the output is not stalled: a two-entry queue sits between the
// input and the embedding engine, which retires one queued item per cycle
// unless the output stalls, and holds each result in an output register,
// so a transfer on each side can happen in every cycle. The rate is set by
// the engine's combinational state update (section end check and bit select).
// Length registers are read live and should be written while the block is idle.
module lsb_stego_embedder
#(
    parameter int HEADER_BYTES = 54
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lse_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lse_pkg::CFG_DATA_W-1:0]  cfg_data,
    lse_in_if.sink                          in_ch,
    lse_out_if.source                       out_ch
);

    logic           q_valid;
    logic           q_pop;
    lse_pkg::item_t q_item;

    lse_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    lse_back
    #(
        .HEADER_BYTES (HEADER_BYTES)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_ch    (out_ch)
    );

endmodule

[bench/tb_lsb_stego_embedder.sv]
`timescale 1ns / 1ps

module tb_lsb_stego_embedder;

    import lse_pkg::*;

    localparam int HDR_BYTES   = 54;
    localparam int RAND_ITEMS  = 550;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_LIMIT = 5000;
    localparam int SETTLE_WAIT = 4;
    localparam int REPORT_MAX  = 10;

    // index past the last register, writes to it are ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] stego;
        status_t           status;
        logic              embedded;
    } stego_result_t;

    typedef enum bit {
        ROW_CFG,
        ROW_ITEM
    } row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  reg_index;
        cmd_t                    command;
        logic [CFG_DATA_W-1:0]   value;
        bit                      typed;
        logic [BYTE_W-1:0]       exp_byte;
        status_t                 exp_status;
        logic                    exp_embedded;
    } dir_row_t;

    localparam int DIR_ROWS = 18;

    // header-phase extremes, overrun, ignored register index
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_CFG,  CFG_MAGIC_LENGTH,     CMD_COVER,   32'd255,        1'b0, 8'h00, ST_OK,       1'b0},
        '{ROW_CFG,  CFG_EXTENSION_LENGTH, CMD_COVER,   32'd15,         1'b0, 8'h00, ST_OK,       1'b0},
        '{ROW_CFG,  CFG_SECRET_SIZE,      CMD_COVER,   32'hFFFF_FFFF,  1'b0, 8'h00, ST_OK,       1'b0},
        '{ROW_CFG,  CFG_UNUSED_INDEX,     CMD_COVER,   32'hFFFF_FFFF,  1'b0, 8'h00, ST_OK,       1'b0},
        '{ROW_ITEM, CFG_MAGIC_LENGTH,     CMD_COVER,   32'h00,         1'b1, 8'h00, ST_OK,       1'b0},
        '{ROW_ITEM, CFG_MAGIC_LENGTH,     CMD_COVER,   32'hFF,         1'b1, 8'hFF, ST_OK,       1'b0},
        '{ROW_ITEM, CFG_MAGIC_LENGTH,     CMD_PAYLOAD, 32'hFF,         1'b0, 8'h00, ST_OK,       1'b0},
        '{ROW_ITEM, CFG_MAGIC_LENGTH,     CMD_PAYLOAD, 32'h00,         1'b1, 8'h00, ST_OVERRUN,  1'b0},
        '{ROW_ITEM, CFG_MAGIC_LENGTH,     CMD_PAYLOAD, 32'hFF,         1'b1, 8'h00, ST_OVERRUN,  1'b0},
        '{ROW_ITEM, CFG_MAGIC_LENGTH,     CMD_COVER,   32'h01,         1'b1, 8'h01, ST_OK,       1'b0},
        '{ROW_ITEM, CFG_MAGIC_LENGTH,     CMD_COVER,   32'hFE,         1'b1, 8'hFE, ST_OK,       1'b0},
        '{ROW_ITEM, CFG_MAGIC_LENGTH,     CMD_COVER,   32'h80,         1'b0, 8'h00, ST_OK,       1'b0},
        '{ROW_ITEM, CFG_MAGIC_LENGTH,     CMD_COVER,   32'h7F,         1'b0, 8'h00, ST_OK,       1'b0},
        '{ROW_CFG,  CFG_MAGIC_LENGTH,     CMD_COVER,   32'd0,          1'b0, 8'h00, ST_OK,       1'b0},
        '{ROW_CFG,  CFG_EXTENSION_LENGTH, CMD_COVER,   32'd0,          1'b0, 8'h00, ST_OK,       1'b0},
        '{ROW_CFG,  CFG_SECRET_SIZE,      CMD_COVER,   32'd0,          1'b0, 8'h00, ST_OK,       1'b0},
        '{ROW_ITEM, CFG_MAGIC_LENGTH,     CMD_COVER,   32'h55,         1'b0, 8'h00, ST_OK,       1'b0},
        '{ROW_ITEM, CFG_MAGIC_LENGTH,     CMD_COVER,   32'hAA,         1'b0, 8'h00, ST_OK,       1'b0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    lse_in_if  in_if ();
    lse_out_if out_if ();

    lsb_stego_embedder #(
        .HEADER_BYTES (HDR_BYTES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_if),
        .out_ch    (out_if)
    );

    // embedding state as predicted
    phase_t            emb_phase;
    int unsigned       hdr_seen;
    logic [4:0]        bit_pos;
    logic [31:0]       sect_bytes;
    logic [BYTE_W-1:0] held_byte;
    bit                held_full;
    logic [MAGIC_W-1:0] magic_len_r;
    logic [EXT_W-1:0]   ext_len_r;
    logic [WORD_W-1:0]  secret_len_r;

    stego_result_t pending_results [$];
    int            mismatches;
    int            cycles;
    bit            calm;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("lsb_stego_embedder regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] section_limit(input phase_t ph);
        if (ph == PH_MAGIC)
            return {24'd0, magic_len_r};
        if (ph == PH_EXT)
            return {28'd0, ext_len_r};
        return secret_len_r;
    endfunction

    function automatic bit in_byte_section(input phase_t ph);
        return (ph == PH_MAGIC) || (ph == PH_EXT) || (ph == PH_SECRET);
    endfunction

    // step past finished or empty sections
    function automatic void skip_done_sections();
        for (int g = 0; g < 8; g++)
        begin
            if (emb_phase == PH_HEADER && hdr_seen >= HDR_BYTES)
            begin
                emb_phase = PH_MAGIC_LEN;
                bit_pos   = '0;
            end
            else if (in_byte_section(emb_phase) && sect_bytes >= section_limit(emb_phase))
            begin
                emb_phase  = phase_t'(emb_phase + 3'd1);
                sect_bytes = '0;
                bit_pos    = '0;
            end
            else
                break;
        end
    endfunction

    function automatic bit embed_predict(input cmd_t cmd, input logic [BYTE_W-1:0] b,
                                         output stego_result_t res);
        logic [WORD_W-1:0] field;
        logic              emb_bit;
        res = '{stego: b, status: ST_OK, embedded: 1'b0};
        if (cmd == CMD_PAYLOAD)
        begin
            if (held_full)
            begin
                res = '{stego: '0, status: ST_OVERRUN, embedded: 1'b0};
                return 1'b1;
            end
            held_byte = b;
            held_full = 1'b1;
            return 1'b0;
        end
        skip_done_sections();
        if (emb_phase == PH_HEADER)
        begin
            hdr_seen++;
            skip_done_sections();
            return 1'b1;
        end
        if (emb_phase == PH_DONE)
            return 1'b1;
        if (!in_byte_section(emb_phase))
        begin
            field = (emb_phase == PH_MAGIC_LEN) ? {24'd0, magic_len_r}
                  : (emb_phase == PH_EXT_LEN)   ? {28'd0, ext_len_r} : secret_len_r;
            emb_bit = field[5'd31 - bit_pos];
            if (bit_pos >= 5'd31)
            begin
                bit_pos    = '0;
                emb_phase  = phase_t'(emb_phase + 3'd1);
                sect_bytes = '0;
            end
            else
                bit_pos++;
        end
        else
        begin
            if (!held_full)
            begin
                res.status = ST_UNDERRUN;
                return 1'b1;
            end
            emb_bit = held_byte[3'd7 - bit_pos[2:0]];
            if (bit_pos >= 5'd7)
            begin
                bit_pos   = '0;
                held_full = 1'b0;
                sect_bytes++;
            end
            else
                bit_pos++;
        end
        res.stego    = {b[7:1], emb_bit};
        res.embedded = 1'b1;
        skip_done_sections();
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    task automatic send_item(input cmd_t cmd, input logic [BYTE_W-1:0] b, input int gap,
                             input bit typed, input stego_result_t typed_res);
        stego_result_t res;
        bit            produced;
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.command   <= cmd;
        in_if.item_byte <= b;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        produced = embed_predict(cmd, b, res);
        if (produced)
            pending_results.push_back(typed ? typed_res : res);
    endtask

    // hold the sender until every expected result has come back
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_MAGIC_LENGTH:     magic_len_r  = value[MAGIC_W-1:0];
            CFG_EXTENSION_LENGTH: ext_len_r    = value[EXT_W-1:0];
            CFG_SECRET_SIZE:      secret_len_r = value;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : result_sink
        int stall;
        stall = 0;
        out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (calm)
            begin
                stall = 0;
                out_if.ready <= 1'b1;
            end
            else if (stall > 0)
            begin
                stall--;
                out_if.ready <= 1'b0;
            end
            else
            begin
                out_if.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        stego_result_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected result: byte %02h status %0d embedded %0b",
                             out_if.stego_byte, out_if.status, out_if.bit_embedded);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_if.stego_byte !== want.stego || out_if.status !== want.status ||
                    out_if.bit_embedded !== want.embedded)
                begin
                    if (mismatches < REPORT_MAX)
                        $display({"mismatch: expected byte %02h status %0d embedded %0b, ",
                                  "got byte %02h status %0d embedded %0b"},
                                 want.stego, want.status, want.embedded,
                                 out_if.stego_byte, out_if.status, out_if.bit_embedded);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int                     random_items;
        int                     seg;
        int                     n;
        int                     r;
        int                     waited;
        bit                     want_payload;
        cmd_t                   cmd;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  value;
        stego_result_t          typed_res;

        mismatches   = 0;
        cycles       = 0;
        calm         = 1'b0;
        emb_phase    = PH_HEADER;
        hdr_seen     = 0;
        bit_pos      = '0;
        sect_bytes   = '0;
        held_byte    = '0;
        held_full    = 1'b0;
        magic_len_r  = '0;
        ext_len_r    = '0;
        secret_len_r = '0;

        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        in_if.valid     <= 1'b0;
        in_if.command   <= CMD_COVER;
        in_if.item_byte <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                wait_idle();
                cfg_write(dir_rows[i].reg_index, dir_rows[i].value);
            end
            else
            begin
                typed_res = '{stego: dir_rows[i].exp_byte, status: dir_rows[i].exp_status,
                              embedded: dir_rows[i].exp_embedded};
                send_item(dir_rows[i].command, dir_rows[i].value[BYTE_W-1:0], pick_gap(),
                          dir_rows[i].typed, typed_res);
            end
        end

        // random part: mostly timely payload bytes so the stream walks every section,
        // with late payloads (underrun) and surplus ones (overrun) mixed in
        random_items = 0;
        seg          = 0;
        while (random_items < RAND_ITEMS)
        begin
            wait_idle();
            calm = ($urandom_range(0, 3) == 0);
            idx  = CFG_INDEX_W'(seg % 3);
            r    = $urandom_range(0, 19);
            case (idx)
                CFG_MAGIC_LENGTH:
                    value = (r < 3) ? 32'd0 : (r < 5) ? 32'd255 : $urandom_range(1, 6);
                CFG_EXTENSION_LENGTH:
                    value = (r < 3) ? 32'd0 : (r < 5) ? 32'd15 : $urandom_range(1, 4);
                default:
                    value = (r < 3) ? 32'd0 : (r < 5) ? 32'hFFFF_FFFF
                          : (r < 6) ? $urandom : $urandom_range(1, 10);
            endcase
            cfg_write(idx, value);
            seg++;
            n = $urandom_range(15, 50);
            repeat (n)
            begin
                r = $urandom_range(0, 99);
                if (!held_full)
                    want_payload = in_byte_section(emb_phase) ? (r < 88) : (r < 8);
                else
                    want_payload = (r < 4);
                cmd = want_payload ? CMD_PAYLOAD : CMD_COVER;
                send_item(cmd, BYTE_W'($urandom_range(0, 255)), calm ? 0 : pick_gap(),
                          1'b0, '0);
                random_items++;
            end
        end

        in_if.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
            $display("%0d expected results never arrived", pending_results.size());

        if (mismatches == 0 && pending_results.size() == 0)
            $display("lsb_stego_embedder regression: pass");
        else
            $display("lsb_stego_embedder regression: fail");
        $finish;
    end

endmodule
